@@ rtl/core/aalti_pkg.sv @@
`timescale 1ns / 1ps
package aalti_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IDX_W      = 10;
    localparam int SEG_W      = 10;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int Q_W        = 58;
    localparam int Y_W        = 60;
    localparam int Q_CAP_BIT  = 56;

    localparam int DEG90  = 90 * 65536;
    localparam int DEG180 = 180 * 65536;
    localparam int DEG360 = 360 * 65536;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 2'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_LON     = 2'd1,
        MODE_LAT     = 2'd2,
        MODE_HEADING = 2'd3
    } t_mode;

endpackage

@@ rtl/core/aalti_in_if.sv @@
`timescale 1ns / 1ps
interface aalti_in_if
    import aalti_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [IDX_W-1:0]       entry_index;
    logic [VALUE_WIDTH-1:0] key_x;
    logic [VALUE_WIDTH-1:0] entry_y;

    modport source (output valid, command, entry_index, key_x, entry_y, input ready);
    modport sink (input valid, command, entry_index, key_x, entry_y, output ready);
endinterface

@@ rtl/core/aalti_out_if.sv @@
`timescale 1ns / 1ps
interface aalti_out_if
    import aalti_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] result_value;
    logic [SEG_W-1:0]       segment_index;
    logic                   status;

    modport source (output valid, result_value, segment_index, status, input ready);
    modport sink (input valid, result_value, segment_index, status, output ready);
endinterface

@@ rtl/core/aalti_muldiv.sv @@
`timescale 1ns / 1ps
module aalti_muldiv
    import aalti_pkg::*;
#(
    parameter int DW = 34
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [DW-1:0]  i_a,
    input  logic signed [DW-1:0]  i_b,
    input  logic signed [DW-1:0]  i_d,
    output logic                  o_done,
    output logic signed [Q_W-1:0] o_quot
);
    localparam int PW  = 2 * DW;
    localparam int CW  = (PW > Q_CAP_BIT + 1) ? PW : Q_CAP_BIT + 1;
    localparam int NCW = $clog2(PW + 1);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_ustate;

    t_ustate         r_state;
    logic [NCW-1:0]  r_cnt;
    logic [PW-1:0]   r_acc;
    logic [PW-1:0]   r_mcand;
    logic [DW-1:0]   r_mplier;
    logic [DW-1:0]   r_dm;
    logic [DW-1:0]   r_rem;
    logic            r_neg;
    logic            r_done;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            rem_ge;
    logic [CW-1:0]   q_ext;
    logic [CW-1:0]   q_cap;
    logic [Q_W-1:0]  q_mag;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    assign rem_sh  = {r_rem, r_acc[PW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dm};
    assign rem_ge  = !rem_sub[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_state  <= U_MUL;
                    end
                end
                U_MUL: begin
                    if (r_cnt == NCW'(DW - 1)) begin
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    if (r_cnt == NCW'(PW - 1)) begin
                        r_state <= U_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    r_acc    <= '0;
                    r_mcand  <= PW'(mag(i_a));
                    r_mplier <= mag(i_b);
                    r_dm     <= mag(i_d);
                    r_neg    <= (i_a[DW-1] ^ i_b[DW-1]) ^ i_d[DW-1];
                    r_cnt    <= '0;
                end
            end
            U_MUL: begin
                r_acc    <= r_acc + (r_mplier[0] ? r_mcand : '0);
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                if (r_cnt == NCW'(DW - 1)) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            U_DIV: begin
                r_rem <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_acc <= {r_acc[PW-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: r_cnt <= '0;
        endcase
    end

    always_comb begin
        q_ext = CW'(r_acc);
        q_cap = CW'(1) << Q_CAP_BIT;
        if (q_ext > q_cap) begin
            q_ext = q_cap;
        end
        q_mag  = Q_W'(q_ext[Q_CAP_BIT:0]);
        o_quot = r_neg ? $signed(-q_mag) : $signed(q_mag);
    end

    assign o_done = r_done;

endmodule

@@ rtl/core/angle_aware_linear_table_interp.sv @@
`timescale 1ns / 1ps
// channel  modport  beat                                          accepted when
// i_in     sink     command, entry_index, key_x, entry_y          valid && ready
// o_out    source   result_value, segment_index, status           valid && ready
// i_cfg    write    i_cfg_idx, i_cfg_data                         i_cfg_we
//
// a load is written to the table as it is accepted; a query steps through the S_FIRST and
// S_LAST reads, bisection steps in S_BIS, the segment reads S_RLO and S_RHI, the serial
// multiply and restoring divide of the mul/div unit, then S_FIN and S_DONE; i_in.ready is
// high only in S_IDLE, so no new beat is taken until the query is through
// synchronous active-low reset clears control and config; table contents stay undefined
// a finished result waits in the output register while the next beat is taken
module angle_aware_linear_table_interp
    import aalti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aalti_in_if.sink              i_in,
    aalti_out_if.source           o_out
);
    localparam int VW = VALUE_WIDTH;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = ((VW + 1 > 26) ? VW + 1 : 26) + 1;

    localparam logic signed [DW-1:0]  D180   = DW'(DEG180);
    localparam logic signed [DW-1:0]  D360   = DW'(DEG360);
    localparam logic signed [Y_W-1:0] Y90    = Y_W'(DEG90);
    localparam logic signed [Y_W-1:0] Y180   = Y_W'(DEG180);
    localparam logic signed [Y_W-1:0] Y360   = Y_W'(DEG360);
    localparam logic signed [Y_W-1:0] Y_VMAX = (Y_W'(1) <<< (VW - 1)) - Y_W'(1);
    localparam logic signed [Y_W-1:0] Y_VMIN = -Y_VMAX - Y_W'(1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FIRST = 9'b000000010,
        S_LAST  = 9'b000000100,
        S_BIS   = 9'b000001000,
        S_RLO   = 9'b000010000,
        S_RHI   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    t_mode                 r_mode;
    logic [VW-1:0]         r_x;
    logic [AW-1:0]         r_lo;
    logic [AW-1:0]         r_hi;
    logic [AW-1:0]         r_mid;
    logic [VW-1:0]         r_xlo;
    logic [VW-1:0]         r_ylo;
    logic signed [Q_W-1:0] r_q;
    logic [VW-1:0]         r_res_value;
    logic [SEG_W-1:0]      r_res_seg;
    logic                  r_res_status;
    logic                  r_out_valid;
    logic [VW-1:0]         r_out_value;
    logic [SEG_W-1:0]      r_out_seg;
    logic                  r_out_status;
    logic [VW-1:0]         r_rd_x;
    logic [VW-1:0]         r_rd_y;
    logic [VW-1:0]         mem_x [TABLE_DEPTH];
    logic [VW-1:0]         mem_y [TABLE_DEPTH];

    logic                  in_acc;
    logic                  load_we;
    logic [NW-1:0]         n_used;
    logic [AW-1:0]         nm1;
    logic [AW-1:0]         nx_lo;
    logic [AW-1:0]         nx_hi;
    logic [AW:0]           mid_sum;
    logic [AW-1:0]         nx_mid;
    logic                  nx_wide;
    logic [AW-1:0]         rd_addr;
    logic signed [DW-1:0]  yd;
    logic signed [DW-1:0]  seg_h;
    logic signed [DW-1:0]  seg_dx;
    logic                  md_start;
    logic                  md_done;
    logic signed [Q_W-1:0] md_quot;
    logic signed [Y_W-1:0] y_fin;
    logic                  out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign load_we  = in_acc && (i_in.command == CMD_LOAD)
                      && (32'(i_in.entry_index) < TABLE_DEPTH);
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    assign n_used = (32'(r_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(r_count);
    assign nm1    = AW'(n_used - NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= MODE_PLAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRY_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                CFG_INTERP_MODE: r_mode  <= t_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_x[AW'(i_in.entry_index)] <= i_in.key_x;
            mem_y[AW'(i_in.entry_index)] <= i_in.entry_y;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // bisection bounds and next read address
    always_comb begin
        nx_lo = r_lo;
        nx_hi = r_hi;
        if (r_state == S_LAST) begin
            nx_lo = '0;
            nx_hi = nm1;
        end else if (r_state == S_BIS) begin
            if ($signed(r_rd_x) > $signed(r_x)) begin
                nx_hi = r_mid;
            end else begin
                nx_lo = r_mid;
            end
        end
        mid_sum = {1'b0, nx_lo} + {1'b0, nx_hi};
        nx_mid  = mid_sum[AW:1];
        nx_wide = (nx_hi - nx_lo) > AW'(1);
        unique case (r_state)
            S_FIRST:       rd_addr = nm1;
            S_LAST, S_BIS: rd_addr = nx_wide ? nx_mid : nx_lo;
            S_RLO:         rd_addr = r_hi;
            default:       rd_addr = '0;
        endcase
    end

    // segment operands
    always_comb begin
        yd = DW'($signed(r_rd_y)) - DW'($signed(r_ylo));
        if (r_mode == MODE_LON || r_mode == MODE_HEADING) begin
            if (yd > D180) begin
                yd = yd - D360;
            end else if (yd < -D180) begin
                yd = yd + D360;
            end
        end
        seg_h  = DW'($signed(r_rd_x)) - DW'($signed(r_xlo));
        seg_dx = DW'($signed(r_x)) - DW'($signed(r_xlo));
    end

    assign md_start = (r_state == S_RHI) && (seg_h != '0);

    aalti_muldiv #(
        .DW (DW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (yd),
        .i_b     (seg_dx),
        .i_d     (seg_h),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    // wrap, clamp and saturate
    always_comb begin
        y_fin = Y_W'($signed(r_ylo)) + Y_W'(r_q);
        unique case (r_mode)
            MODE_LON: begin
                if (y_fin >= Y180) begin
                    y_fin = y_fin - Y360;
                end else if (y_fin < -Y180) begin
                    y_fin = y_fin + Y360;
                end
            end
            MODE_LAT: begin
                if (y_fin > Y90) begin
                    y_fin = Y90;
                end else if (y_fin < -Y90) begin
                    y_fin = -Y90;
                end
            end
            MODE_HEADING: begin
                if (y_fin >= Y360) begin
                    y_fin = y_fin - Y360;
                end else if (y_fin < 0) begin
                    y_fin = y_fin + Y360;
                end
            end
            default: ;
        endcase
        if (y_fin > Y_VMAX) begin
            y_fin = Y_VMAX;
        end else if (y_fin < Y_VMIN) begin
            y_fin = Y_VMIN;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.command == CMD_QUERY) begin
                    n_state = (n_used == '0) ? S_DONE : S_FIRST;
                end
            end
            S_FIRST: begin
                n_state = ($signed(r_x) <= $signed(r_rd_x)) ? S_DONE : S_LAST;
            end
            S_LAST: begin
                if ($signed(r_x) >= $signed(r_rd_x)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = nx_wide ? S_BIS : S_RLO;
                end
            end
            S_BIS:   n_state = nx_wide ? S_BIS : S_RLO;
            S_RLO:   n_state = S_RHI;
            S_RHI:   n_state = (seg_h == '0) ? S_FIN : S_DIV;
            S_DIV:   n_state = md_done ? S_FIN : S_DIV;
            S_FIN:   n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x          <= i_in.key_x;
                r_res_value  <= '0;
                r_res_seg    <= '0;
                r_res_status <= ST_EMPTY;
            end
            S_FIRST: begin
                r_res_value  <= r_rd_y;
                r_res_seg    <= '0;
                r_res_status <= ST_OK;
            end
            S_LAST: begin
                r_res_value <= r_rd_y;
                r_res_seg   <= SEG_W'(nm1);
                r_lo        <= nx_lo;
                r_hi        <= nx_hi;
                r_mid       <= nx_mid;
            end
            S_BIS: begin
                r_lo  <= nx_lo;
                r_hi  <= nx_hi;
                r_mid <= nx_mid;
            end
            S_RLO: begin
                r_xlo     <= r_rd_x;
                r_ylo     <= r_rd_y;
                r_res_seg <= SEG_W'(r_lo);
            end
            S_RHI: begin
                r_q <= '0;
            end
            S_DIV: begin
                if (md_done) begin
                    r_q <= md_quot;
                end
            end
            S_FIN: begin
                r_res_value <= VW'(y_fin);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_value  <= r_res_value;
            r_out_seg    <= r_res_seg;
            r_out_status <= r_res_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_value  = r_out_value;
    assign o_out.segment_index = r_out_seg;
    assign o_out.status        = r_out_status;

endmodule
